/* hw/rtl/tcl_pkg.sv */
package tcl_pkg;

	// List depths
	localparam int TGT_DEPTH = 16;
	localparam int RPL_DEPTH = 8;

	// Index and count widths
	localparam int TGT_AW = (TGT_DEPTH > 1) ? $clog2(TGT_DEPTH) : 1;
	localparam int RPL_AW = (RPL_DEPTH > 1) ? $clog2(RPL_DEPTH) : 1;
	localparam int TGT_CW = $clog2(TGT_DEPTH + 1);
	localparam int RPL_CW = $clog2(RPL_DEPTH + 1);
	localparam int CNT_W = (TGT_CW > RPL_CW) ? TGT_CW : RPL_CW;

	// Decay: seconds per minute and reciprocal for small differences
	localparam int unsigned SEC_PER_MIN = 60;
	localparam int unsigned DECAY_SPAN = SEC_PER_MIN * TGT_DEPTH;
	localparam int DIFF_W = $clog2(DECAY_SPAN + 1);
	localparam int RECIP_SH = 20;
	localparam int unsigned RECIP_M = ((1 << RECIP_SH) + SEC_PER_MIN - 1) / SEC_PER_MIN;
	localparam int RECIP_W = $clog2(RECIP_M + 1);

	// Configuration register indexes
	localparam logic REG_MAX_TARGETS = 1'b0;
	localparam logic REG_MAX_REPLIES = 1'b1;

	// Actions and hit kinds
	localparam logic ACT_ADD_TARGET = 1'b0;
	localparam logic ACT_ADD_REPLY = 1'b1;
	localparam logic [1:0] HIT_NEW = 2'd0;
	localparam logic [1:0] HIT_TARGET = 2'd1;
	localparam logic [1:0] HIT_REPLY = 2'd2;

	typedef struct packed {
		logic        action;
		logic [31:0] target_id;
		logic [31:0] now_seconds;
	} in_word_t;

	typedef struct packed {
		logic       allowed;
		logic [1:0] hit_kind;
		logic [4:0] target_count;
	} out_word_t;

endpackage

/* hw/rtl/tcl_ram.sv */
module tcl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* hw/rtl/target_change_limiter_top.sv */
// Target change limiter for one source.
// Input channel (in_valid/in_ready/in_word): one word per event, action
// add_target or add_reply, with the target id and the time in seconds.
// Output channel (out_valid/out_ready/out_word): exactly one result word per
// input word, in order: allowed, hit kind and the target list fill.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): index 0 writes
// max_targets, index 1 writes max_replies; always ready.
// Both lists live in registered-read RAMs and are walked one entry a cycle:
// a lookup scan, then a shift pass that moves entries back one place, then a
// write of the id at the front; a refused target skips the shift and write.
// The result goes from the done state into the output register, and the
// next word is taken in the idle state that follows.
// One item is worked on at a time; a new word is taken as soon as the
// previous result sits in the output register, even while it is stalled.
// If the receiver stalls, the finished result waits in the done state.
// Reset clears the fill counts, the decay time and loads the default limits
// (10 targets, 5 replies); list contents need no clearing.
module target_change_limiter_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  tcl_pkg::in_word_t   in_word,
	output logic                out_valid,
	input  logic                out_ready,
	output tcl_pkg::out_word_t  out_word,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                cfg_index,
	input  logic [4:0]          cfg_data
);
	import tcl_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_SCAN   = 6'b000010,
		ST_DECIDE = 6'b000100,
		ST_SHIFT  = 6'b001000,
		ST_FRONT  = 6'b010000,
		ST_DONE   = 6'b100000
	} state_t;

	state_t state_q;

	logic [4:0]        max_targets_q;
	logic [3:0]        max_replies_q;
	logic [TGT_CW-1:0] tused_q;
	logic [RPL_CW-1:0] rused_q;
	logic [31:0]       last_decay_q;

	logic        act_q;
	logic [31:0] id_q;
	logic [31:0] now_q;
	logic        sel_q;     // 0 target list, 1 reply list
	logic        push_q;
	logic [CNT_W-1:0] cnt_q;
	logic        pend_s1;
	logic [CNT_W-1:0] idx_s1;
	out_word_t   res_q;
	out_word_t   out_q;
	logic        out_valid_q;

	// RAM ports
	logic              t_we, r_we;
	logic [TGT_AW-1:0] t_waddr, t_raddr;
	logic [RPL_AW-1:0] r_waddr, r_raddr;
	logic [31:0]       wdata;
	logic [31:0]       t_rdata, r_rdata, rdata;
	logic              we;
	logic [CNT_W-1:0]  rd_idx, wr_idx;

	tcl_ram #(.WIDTH(32), .DEPTH(TGT_DEPTH), .AW(TGT_AW)) u_tgt_ram (
		.clk(clk), .we(t_we), .waddr(t_waddr), .wdata(wdata),
		.raddr(t_raddr), .rdata(t_rdata)
	);

	tcl_ram #(.WIDTH(32), .DEPTH(RPL_DEPTH), .AW(RPL_AW)) u_rpl_ram (
		.clk(clk), .we(r_we), .waddr(r_waddr), .wdata(wdata),
		.raddr(r_raddr), .rdata(r_rdata)
	);

	// Effective limits
	logic [TGT_CW-1:0] tlim;
	logic [RPL_CW-1:0] rlim;
	always_comb begin
		if (32'(max_targets_q) > TGT_DEPTH) tlim = TGT_CW'(TGT_DEPTH);
		else tlim = TGT_CW'(max_targets_q);
		if (32'(max_replies_q) > RPL_DEPTH) rlim = RPL_CW'(RPL_DEPTH);
		else if (max_replies_q == 4'd0) rlim = RPL_CW'(1);
		else rlim = RPL_CW'(max_replies_q);
	end

	// Lookup compare and bound of the active list
	logic [CNT_W-1:0] used_sel;
	logic             match;
	assign rdata = sel_q ? r_rdata : t_rdata;
	assign used_sel = sel_q ? CNT_W'(rused_q) : CNT_W'(tused_q);
	assign match = pend_s1 && (rdata == id_q);

	// Decay: whole minutes since last decay, clamped to the list fill
	logic [31:0]         diff;
	logic                time_ok;
	logic                span_big;
	logic [DIFF_W+RECIP_W-1:0] prod;
	logic [TGT_CW-1:0]   mins_small;
	logic [TGT_CW-1:0]   tused_dec;
	logic                decay_hit;
	always_comb begin
		diff = now_q - last_decay_q;
		time_ok = now_q >= last_decay_q;
		span_big = diff >= DECAY_SPAN;
		prod = (DIFF_W+RECIP_W)'(diff[DIFF_W-1:0]) * (DIFF_W+RECIP_W)'(RECIP_M);
		mins_small = TGT_CW'(prod >> RECIP_SH);
		decay_hit = time_ok && (span_big || mins_small != '0);
		if (!decay_hit) tused_dec = tused_q;
		else if (span_big || mins_small >= tused_q) tused_dec = '0;
		else tused_dec = tused_q - mins_small;
	end

	logic [RPL_CW-1:0] rused_ev;
	assign rused_ev = (rused_q >= rlim && rused_q != '0) ? rused_q - RPL_CW'(1) : rused_q;

	// RAM address and write control
	always_comb begin
		we = (state_q == ST_SHIFT && pend_s1) || (state_q == ST_FRONT);
		wr_idx = (state_q == ST_FRONT) ? '0 : idx_s1 + CNT_W'(1);
		wdata = (state_q == ST_FRONT) ? id_q : rdata;
		rd_idx = (state_q == ST_SHIFT) ? cnt_q - CNT_W'(1) : cnt_q;
		t_we = we && !sel_q;
		r_we = we && sel_q;
		t_waddr = wr_idx[TGT_AW-1:0];
		r_waddr = wr_idx[RPL_AW-1:0];
		t_raddr = rd_idx[TGT_AW-1:0];
		r_raddr = rd_idx[RPL_AW-1:0];
	end

	assign in_ready = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_word = out_q;

	logic out_load;
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_targets_q <= 5'd10;
			max_replies_q <= 4'd5;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_MAX_TARGETS: max_targets_q <= cfg_data;
				REG_MAX_REPLIES: max_replies_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= '{allowed: res_q.allowed, hit_kind: res_q.hit_kind,
				target_count: 5'(tused_q)};
		end
	end

	// Item sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			tused_q <= '0;
			rused_q <= '0;
			last_decay_q <= '0;
			pend_s1 <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					pend_s1 <= 1'b0;
					if (in_valid) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (match) begin
						pend_s1 <= 1'b0;
						state_q <= ST_SHIFT;
					end else if (cnt_q == used_sel) begin
						pend_s1 <= 1'b0;
						if (!sel_q) begin
							state_q <= ST_SCAN;
						end else if (act_q == ACT_ADD_TARGET) begin
							state_q <= ST_DECIDE;
						end else begin
							rused_q <= rused_ev;
							state_q <= ST_SHIFT;
						end
					end else begin
						pend_s1 <= 1'b1;
					end
				end
				ST_DECIDE: begin
					tused_q <= tused_dec;
					if (decay_hit) begin
						last_decay_q <= now_q;
					end
					state_q <= (tused_dec >= tlim) ? ST_DONE : ST_SHIFT;
				end
				ST_SHIFT: begin
					if (cnt_q == '0) begin
						pend_s1 <= 1'b0;
						state_q <= ST_FRONT;
					end else begin
						pend_s1 <= 1'b1;
					end
				end
				ST_FRONT: begin
					if (push_q) begin
						if (sel_q) rused_q <= rused_q + RPL_CW'(1);
						else tused_q <= tused_q + TGT_CW'(1);
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Item datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				act_q <= in_word.action;
				id_q <= in_word.target_id;
				now_q <= in_word.now_seconds;
				sel_q <= (in_word.action == ACT_ADD_REPLY);
				cnt_q <= '0;
				push_q <= 1'b0;
				res_q.allowed <= 1'b1;
				res_q.hit_kind <= HIT_NEW;
			end
			ST_SCAN: begin
				if (match) begin
					cnt_q <= idx_s1;
					res_q.hit_kind <= sel_q ? HIT_REPLY : HIT_TARGET;
				end else if (cnt_q == used_sel) begin
					if (!sel_q) begin
						sel_q <= 1'b1;
						cnt_q <= '0;
					end else if (act_q == ACT_ADD_REPLY) begin
						cnt_q <= CNT_W'(rused_ev);
						push_q <= 1'b1;
					end
				end else begin
					idx_s1 <= cnt_q;
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end
			ST_DECIDE: begin
				sel_q <= 1'b0;
				cnt_q <= CNT_W'(tused_dec);
				push_q <= 1'b1;
				if (tused_dec >= tlim) begin
					res_q.allowed <= 1'b0;
				end
			end
			ST_SHIFT: begin
				if (cnt_q != '0) begin
					idx_s1 <= cnt_q - CNT_W'(1);
					cnt_q <= cnt_q - CNT_W'(1);
				end
			end
			default: ;
		endcase
	end

endmodule
